// ----- sv/limit_order_matcher_assert.svh -----
// Assertion macros for the limit order matcher.
// Included by the RTL files that assert; depends on nothing else.
`ifndef LIMIT_ORDER_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
`define LOM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define LOM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define LOM_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define LOM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- sv/lom_pkg.sv -----
// Shared types and constants of the limit order matcher.
// Depends on nothing; used by limit_order_matcher.
package lom_pkg;

   localparam int DEF_NUM_SYMBOLS = 16;
   localparam int DEF_BOOK_DEPTH  = 32;
   localparam int COMMISSION_DIVISOR = 100;
   localparam int PRODUCT_BITS = 64;

   localparam logic SIDE_ASK = 1'b0;
   localparam logic SIDE_BID = 1'b1;

   localparam logic KIND_TRADE = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_DROPPED  = 2'd1;
   localparam logic [1:0] STATUS_REJECTED = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_MUL,
      ST_DIV,
      ST_TRADE,
      ST_RESTCHK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_MATCH,
      PH_REST,
      PH_OWN
   } phase_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] price;
      logic [31:0] qty;
      logic [7:0]  client;
      logic [32:0] deadline;
      logic        no_expiry;
      logic [31:0] seq;
   } entry_type;

endpackage

// ----- sv/limit_order_matcher.sv -----
// Top level of the limit order matcher: FSM, book memory and commission divider.
// Depends on lom_pkg and limit_order_matcher_assert.svh.
//
// Usage: an order beat is taken when start is high and busy is low. Results
// appear on the rsp_ ports for one cycle each, marked by rsp_valid; the
// receiver cannot stall them. Every order ends with a completion beat that
// has rsp_last set.
// An order that arrives out of time order is answered with a rejection in
// the cycle after it is taken, and busy stays low. Otherwise each scan of a
// book reads its BOOK_DEPTH entries through the single memory read port
// and is followed by a decision step. Every expired head costs one scan and
// decision, and every fill costs one scan and decision plus the multiply,
// the four-step divide by one hundred and the trade beat.
// An order with nothing to match or rest keeps busy high through a scan
// and decision of the opposite book, the rest check, a scan and decision of
// its own book and the completion beat; a resting residue adds a scan and
// decision that place it in its own book. After reset the block clears the
// book memory, one entry a cycle, holding busy high meanwhile.
`include "limit_order_matcher_assert.svh"
module limit_order_matcher #(
   parameter int NUM_SYMBOLS = lom_pkg::DEF_NUM_SYMBOLS,
   parameter int BOOK_DEPTH  = lom_pkg::DEF_BOOK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_order_time,
   input  logic [3:0]  req_symbol_id,
   input  logic [7:0]  req_client_id,
   input  logic        req_is_buy,
   input  logic [31:0] req_limit_price,
   input  logic [31:0] req_order_quantity,
   input  logic signed [31:0] req_lifetime,
   output logic        rsp_valid,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_buyer_id,
   output logic [7:0]  rsp_seller_id,
   output logic [31:0] rsp_fill_quantity,
   output logic [31:0] rsp_fill_price,
   output logic [63:0] rsp_commission,
   output logic [31:0] rsp_remaining_quantity,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   localparam int MEM_DEPTH = 2 * NUM_SYMBOLS * BOOK_DEPTH;
   localparam int ADDR_W = $clog2(MEM_DEPTH);
   localparam int IDX_W = $clog2(BOOK_DEPTH);
   localparam int CNT_W = $clog2(BOOK_DEPTH + 1);
   localparam int SYM_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int DIV_CHUNK = 16;
   localparam int DIV_STEPS = lom_pkg::PRODUCT_BITS / DIV_CHUNK;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int REM_W = $clog2(lom_pkg::COMMISSION_DIVISOR);
   localparam int PART_W = REM_W + DIV_CHUNK;
   localparam int RECIP_SHIFT = PART_W + REM_W;
   localparam int RECIP_W = RECIP_SHIFT - REM_W + 1;
   localparam int MULT_W = PART_W + RECIP_W;
   localparam longint RECIP = ((longint'(1) << RECIP_SHIFT)
      + longint'(lom_pkg::COMMISSION_DIVISOR) - 1) / longint'(lom_pkg::COMMISSION_DIVISOR);

   lom_pkg::entry_type mem [MEM_DEPTH];
   lom_pkg::entry_type mem_q_ff;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic               wr_en;
   lom_pkg::entry_type wr_data;

   lom_pkg::state_type state_ff, state_in;
   lom_pkg::phase_type phase_ff, phase_in;

   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [31:0] cur_ff, cur_in, arr_ff, arr_in;
   logic [31:0] ts_ff, ts_in, seq_ff, seq_in, price_ff, price_in, qty_ff, qty_in;
   logic [SYM_W-1:0] sym_ff, sym_in, sym_mod;
   logic [7:0]  client_ff, client_in;
   logic        buy_ff, buy_in;
   logic signed [31:0] dur_ff, dur_in;
   logic [1:0]  st_ff, st_in;
   logic [CNT_W-1:0] n_ff, n_in;

   logic        side_ff, side_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic        pend_ff, pend_in;
   logic [IDX_W-1:0] ridx_ff, ridx_in;
   logic        best_ok_ff, best_ok_in, free_ok_ff, free_ok_in;
   lom_pkg::entry_type best_ff, best_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in, free_idx_ff, free_idx_in;

   logic [31:0] fill_ff, fill_in;
   logic [63:0] prod_ff, prod_in, quot_ff, quot_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;

   logic        rv_ff, rv_in, rk_ff, rk_in, rl_ff, rl_in;
   logic [7:0]  rb_ff, rb_in, rs_ff, rs_in;
   logic [31:0] rq_ff, rq_in, rp_ff, rp_in, rr_ff, rr_in;
   logic [63:0] rc_ff, rc_in;
   logic [1:0]  rst_ff, rst_in;

   logic [ADDR_W-1:0] base_addr;
   logic        take_better, expired;
   logic [PART_W-1:0] div_part, div_back;
   logic [MULT_W-1:0] div_prod;
   logic [DIV_CHUNK-1:0] div_quot;
   logic [32:0] deadline;
   logic [31:0] left_qty;

   always_comb begin
      sym_mod = '0;
      for (int v = 0; v < 16; v++) begin
         if (req_symbol_id == 4'(v)) begin
            sym_mod = SYM_W'(v % NUM_SYMBOLS);
         end
      end
   end

   assign base_addr = ADDR_W'((32'(side_ff) * NUM_SYMBOLS + 32'(sym_ff)) * BOOK_DEPTH);
   assign expired = best_ok_ff && !best_ff.no_expiry && ({1'b0, cur_ff} >= best_ff.deadline);
   assign left_qty = best_ff.qty - fill_ff;

   assign div_part = {rem_ff, prod_ff[lom_pkg::PRODUCT_BITS-1 -: DIV_CHUNK]};
   assign div_prod = MULT_W'(div_part) * MULT_W'(RECIP);
   assign div_quot = div_prod[RECIP_SHIFT +: DIV_CHUNK];
   assign div_back = PART_W'(div_quot) * PART_W'(lom_pkg::COMMISSION_DIVISOR);

   always_comb begin
      if (!best_ok_ff) begin
         take_better = 1'b1;
      end else if (mem_q_ff.price == best_ff.price) begin
         take_better = mem_q_ff.seq < best_ff.seq;
      end else if (side_ff == lom_pkg::SIDE_BID) begin
         take_better = mem_q_ff.price > best_ff.price;
      end else begin
         take_better = mem_q_ff.price < best_ff.price;
      end
   end

   always_comb begin
      if (dur_ff == -32'sd1) begin
         deadline = '0;
      end else if (dur_ff > 32'sd0) begin
         deadline = {1'b0, ts_ff} + {1'b0, dur_ff[31:0]};
      end else begin
         deadline = {1'b0, ts_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lom_pkg::ST_CLEAR;
         phase_ff <= lom_pkg::PH_MATCH;
         clr_ff <= '0;
         cur_ff <= '0;
         arr_ff <= '0;
         pend_ff <= 1'b0;
         rv_ff <= 1'b0;
         n_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         clr_ff <= clr_in;
         cur_ff <= cur_in;
         arr_ff <= arr_in;
         pend_ff <= pend_in;
         rv_ff <= rv_in;
         n_ff <= n_in;
      end
      ts_ff <= ts_in;        seq_ff <= seq_in;      price_ff <= price_in;
      qty_ff <= qty_in;      sym_ff <= sym_in;      client_ff <= client_in;
      buy_ff <= buy_in;      dur_ff <= dur_in;      st_ff <= st_in;
      side_ff <= side_in;    cnt_ff <= cnt_in;      ridx_ff <= ridx_in;
      best_ok_ff <= best_ok_in;   free_ok_ff <= free_ok_in;
      best_ff <= best_in;    best_idx_ff <= best_idx_in;   free_idx_ff <= free_idx_in;
      fill_ff <= fill_in;    prod_ff <= prod_in;    quot_ff <= quot_in;
      rem_ff <= rem_in;      dcnt_ff <= dcnt_in;
      rk_ff <= rk_in;        rl_ff <= rl_in;        rb_ff <= rb_in;
      rs_ff <= rs_in;        rq_ff <= rq_in;        rp_ff <= rp_in;
      rr_ff <= rr_in;        rc_ff <= rc_in;        rst_ff <= rst_in;
   end

   always_comb begin
      state_in = state_ff;   phase_in = phase_ff;   clr_in = clr_ff;
      cur_in = cur_ff;       arr_in = arr_ff;       ts_in = ts_ff;
      seq_in = seq_ff;       price_in = price_ff;   qty_in = qty_ff;
      sym_in = sym_ff;       client_in = client_ff; buy_in = buy_ff;
      dur_in = dur_ff;       st_in = st_ff;         n_in = n_ff;
      side_in = side_ff;     cnt_in = cnt_ff;       pend_in = 1'b0;
      ridx_in = ridx_ff;     best_ok_in = best_ok_ff;   free_ok_in = free_ok_ff;
      best_in = best_ff;     best_idx_in = best_idx_ff; free_idx_in = free_idx_ff;
      fill_in = fill_ff;     prod_in = prod_ff;     quot_in = quot_ff;
      rem_in = rem_ff;       dcnt_in = dcnt_ff;
      rv_in = 1'b0;          rk_in = rk_ff;         rl_in = rl_ff;
      rb_in = rb_ff;         rs_in = rs_ff;         rq_in = rq_ff;
      rp_in = rp_ff;         rr_in = rr_ff;         rc_in = rc_ff;
      rst_in = rst_ff;
      rd_en = 1'b0;
      rd_addr = base_addr + ADDR_W'(cnt_ff[IDX_W-1:0]);
      wr_en = 1'b0;
      wr_addr = base_addr + ADDR_W'(best_idx_ff);
      wr_data = best_ff;
      busy = 1'b1;

      case (state_ff)
         lom_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               state_in = lom_pkg::ST_IDLE;
            end
         end
         lom_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ts_in = req_order_time;
               sym_in = sym_mod;
               client_in = req_client_id;
               buy_in = req_is_buy;
               price_in = req_limit_price;
               qty_in = req_order_quantity;
               dur_in = req_lifetime;
               if (req_order_time < cur_ff) begin
                  rv_in = 1'b1;
                  rk_in = lom_pkg::KIND_DONE;
                  rb_in = '0; rs_in = '0; rq_in = '0; rp_in = '0; rc_in = '0;
                  rr_in = req_order_quantity;
                  rst_in = lom_pkg::STATUS_REJECTED;
                  rl_in = 1'b1;
               end else begin
                  cur_in = req_order_time;
                  seq_in = arr_ff;
                  arr_in = arr_ff + 32'd1;
                  st_in = lom_pkg::STATUS_ACCEPTED;
                  n_in = '0;
                  phase_in = lom_pkg::PH_MATCH;
                  side_in = !req_is_buy;
                  cnt_in = '0;
                  best_ok_in = 1'b0;
                  free_ok_in = 1'b0;
                  state_in = lom_pkg::ST_SCAN;
               end
            end
         end
         lom_pkg::ST_SCAN: begin
            if (cnt_ff != CNT_W'(BOOK_DEPTH)) begin
               rd_en = 1'b1;
               pend_in = 1'b1;
               ridx_in = cnt_ff[IDX_W-1:0];
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (mem_q_ff.valid) begin
                  if (take_better) begin
                     best_ok_in = 1'b1;
                     best_in = mem_q_ff;
                     best_idx_in = ridx_ff;
                  end
               end else if (!free_ok_ff) begin
                  free_ok_in = 1'b1;
                  free_idx_in = ridx_ff;
               end
            end else if (cnt_ff == CNT_W'(BOOK_DEPTH)) begin
               state_in = lom_pkg::ST_DECIDE;
            end
         end
         lom_pkg::ST_DECIDE: begin
            cnt_in = '0;
            best_ok_in = 1'b0;
            free_ok_in = 1'b0;
            case (phase_ff)
               lom_pkg::PH_MATCH: begin
                  if (expired) begin
                     wr_en = 1'b1;
                     wr_data.valid = 1'b0;
                     state_in = lom_pkg::ST_SCAN;
                  end else if (!best_ok_ff || qty_ff == 32'd0 ||
                               (buy_ff ? (price_ff < best_ff.price)
                                       : (best_ff.price < price_ff))) begin
                     state_in = lom_pkg::ST_RESTCHK;
                  end else begin
                     fill_in = (qty_ff < best_ff.qty) ? qty_ff : best_ff.qty;
                     state_in = lom_pkg::ST_MUL;
                  end
               end
               lom_pkg::PH_REST: begin
                  if (free_ok_ff) begin
                     wr_en = 1'b1;
                     wr_addr = base_addr + ADDR_W'(free_idx_ff);
                     wr_data.valid = 1'b1;
                     wr_data.price = price_ff;
                     wr_data.qty = qty_ff;
                     wr_data.client = client_ff;
                     wr_data.deadline = deadline;
                     wr_data.no_expiry = (dur_ff == -32'sd1);
                     wr_data.seq = seq_ff;
                  end else begin
                     st_in = lom_pkg::STATUS_DROPPED;
                  end
                  phase_in = lom_pkg::PH_OWN;
                  state_in = lom_pkg::ST_SCAN;
               end
               default: begin
                  if (expired) begin
                     wr_en = 1'b1;
                     wr_data.valid = 1'b0;
                     state_in = lom_pkg::ST_SCAN;
                  end else begin
                     state_in = lom_pkg::ST_DONE;
                  end
               end
            endcase
         end
         lom_pkg::ST_MUL: begin
            prod_in = 64'(fill_ff) * 64'(best_ff.price);
            rem_in = '0;
            quot_in = '0;
            dcnt_in = '0;
            state_in = lom_pkg::ST_DIV;
         end
         lom_pkg::ST_DIV: begin
            prod_in = prod_ff << DIV_CHUNK;
            rem_in = REM_W'(div_part - div_back);
            quot_in = (quot_ff << DIV_CHUNK) | 64'(div_quot);
            dcnt_in = dcnt_ff + DIV_CNT_W'(1);
            if (dcnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = lom_pkg::ST_TRADE;
            end
         end
         lom_pkg::ST_TRADE: begin
            rv_in = 1'b1;
            rk_in = lom_pkg::KIND_TRADE;
            rb_in = buy_ff ? client_ff : best_ff.client;
            rs_in = buy_ff ? best_ff.client : client_ff;
            rq_in = fill_ff;
            rp_in = best_ff.price;
            rc_in = {quot_ff[62:0], 1'b0};
            rr_in = '0;
            rst_in = lom_pkg::STATUS_ACCEPTED;
            rl_in = 1'b0;
            wr_en = 1'b1;
            wr_data.qty = left_qty;
            wr_data.valid = (left_qty != 32'd0);
            qty_in = qty_ff - fill_ff;
            n_in = n_ff + CNT_W'(1);
            if (n_ff == CNT_W'(BOOK_DEPTH - 1)) begin
               state_in = lom_pkg::ST_RESTCHK;
            end else begin
               state_in = lom_pkg::ST_SCAN;
            end
         end
         lom_pkg::ST_RESTCHK: begin
            side_in = buy_ff;
            cnt_in = '0;
            best_ok_in = 1'b0;
            free_ok_in = 1'b0;
            if (qty_ff != 32'd0 && dur_ff != 32'sd0) begin
               phase_in = lom_pkg::PH_REST;
            end else begin
               phase_in = lom_pkg::PH_OWN;
            end
            state_in = lom_pkg::ST_SCAN;
         end
         lom_pkg::ST_DONE: begin
            rv_in = 1'b1;
            rk_in = lom_pkg::KIND_DONE;
            rb_in = '0; rs_in = '0; rq_in = '0; rp_in = '0; rc_in = '0;
            rr_in = qty_ff;
            rst_in = st_ff;
            rl_in = 1'b1;
            state_in = lom_pkg::ST_IDLE;
         end
         default: begin
            state_in = lom_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_result_kind = rk_ff;
   assign rsp_buyer_id = rb_ff;
   assign rsp_seller_id = rs_ff;
   assign rsp_fill_quantity = rq_ff;
   assign rsp_fill_price = rp_ff;
   assign rsp_commission = rc_ff;
   assign rsp_remaining_quantity = rr_ff;
   assign rsp_status = rst_ff;
   assign rsp_last = rl_ff;

   `LOM_ASSERT_IMPLY(a_trade_not_last, clock, reset,
      rv_ff && rk_ff == lom_pkg::KIND_TRADE, !rl_ff && rr_ff == 32'd0)
   `LOM_ASSERT_IMPLY(a_fill_bound, clock, reset,
      state_ff != lom_pkg::ST_CLEAR, n_ff <= CNT_W'(BOOK_DEPTH))
   `LOM_ASSERT_NEXT(a_accept_busy, clock, reset,
      start && !busy && req_order_time >= cur_ff, busy && !rv_ff)
   `LOM_ASSERT_IMPLY(a_no_write_in_scan, clock, reset,
      state_ff == lom_pkg::ST_SCAN, !wr_en)

endmodule
